// ===== rtl/bmhq_pkg.sv =====
// Shared definitions for the binary max-heap priority queue.
// Holds parameter defaults, operation and status codes, and the sequencer state type.
// No dependencies.
package bmhq_pkg;

   localparam int CAPACITY_DEF    = 1024;
   localparam int VALUE_WIDTH_DEF = 30;

   // operation codes carried on req_tuser
   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   // status codes carried on rsp_tuser
   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_EXTRACTED = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPCMP,
      S_ROOT,
      S_LAST,
      S_DNL,
      S_DNR,
      S_FIN,
      S_EMIT
   } bmhq_state_type;

endpackage

// ===== rtl/bmhq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Used for the heap storage. No package dependencies.
module bmhq_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/binary_max_heap_queue.sv =====
// Binary max-heap priority queue, top level: sequencer and heap RAM instance.
// Depends on bmhq_pkg and bmhq_ram.
//
//  channel | dir | handshake                | payload
//  req     | in  | req_tvalid / req_tready  | tuser: func; tdata: value
//  rsp     | out | rsp_tvalid / rsp_tready  | tuser: status; tdata: max_value, occupancy
//
// An insert climbs with the new value level by level; an extract moves the last entry to the
// root and sinks it, reading both children of each level in turn on the one read port. An
// extract that empties the heap only reads the root; a full insert or an empty extract goes
// straight to the result.
// A new item is taken while the last result waits in the output register; a stalled output
// holds the sequencer only at its final step. Reset clears count and control, not the RAM.
module binary_max_heap_queue #(
   parameter int CAPACITY    = bmhq_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF,
   localparam int AW   = $clog2(CAPACITY),
   localparam int CW   = $clog2(CAPACITY + 1),
   localparam int REQW = ((VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSPW = ((VALUE_WIDTH + CW + 7) / 8) * 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [REQW-1:0] req_tdata,   // [VALUE_WIDTH-1:0] value
   input  logic [0:0]      req_tuser,   // [0] func
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RSPW-1:0] rsp_tdata,   // [VALUE_WIDTH-1:0] max_value, then occupancy
   output logic [1:0]      rsp_tuser    // [1:0] status
);

   localparam int IW = AW + 2;   // room for child indexes 2*pos+2

   bmhq_pkg::bmhq_state_type state_ff, state_in;

   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] child_ff, child_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic [1:0]             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSPW-1:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr, pos_par, pos_par2, par_cnt, cidx;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data, cval, req_value;
   logic [IW-1:0]          count_x, left_ix, right_ix, next_left;
   logic                   req_fire, req_func, is_full, is_empty, take_right, out_free;

   bmhq_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(CAPACITY)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == bmhq_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_func   = req_tuser[0];
   assign req_value  = req_tdata[VALUE_WIDTH-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign count_x  = IW'(count_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // index arithmetic of the tree
   assign par_cnt   = AW'((count_ff - 1'b1) >> 1);
   assign pos_par   = (pos_ff - 1'b1) >> 1;
   assign pos_par2  = (pos_par - 1'b1) >> 1;
   assign left_ix   = {1'b0, pos_ff, 1'b1};
   assign right_ix  = left_ix + 1'b1;

   // larger child, left one on a tie; right slot only counts if it is in the heap
   assign take_right = (right_ix < count_x) && (rd_data > child_ff);
   assign cval       = take_right ? rd_data : child_ff;
   assign cidx       = take_right ? AW'(right_ix) : AW'(left_ix);
   assign next_left  = {1'b0, cidx, 1'b1};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_func == bmhq_pkg::FUNC_INSERT) begin
                  if (is_full) begin
                     state_in = bmhq_pkg::S_EMIT;
                  end else if (is_empty) begin
                     state_in = bmhq_pkg::S_FIN;
                  end else begin
                     state_in = bmhq_pkg::S_UPCMP;
                  end
               end else begin
                  state_in = is_empty ? bmhq_pkg::S_EMIT : bmhq_pkg::S_ROOT;
               end
            end
         end
         bmhq_pkg::S_UPCMP: begin
            if (cur_ff > rd_data) begin
               state_in = (pos_par == '0) ? bmhq_pkg::S_FIN : bmhq_pkg::S_UPCMP;
            end else begin
               state_in = bmhq_pkg::S_EMIT;
            end
         end
         bmhq_pkg::S_ROOT: begin
            state_in = is_empty ? bmhq_pkg::S_EMIT : bmhq_pkg::S_LAST;
         end
         bmhq_pkg::S_LAST: begin
            state_in = (count_ff > CW'(1)) ? bmhq_pkg::S_DNL : bmhq_pkg::S_FIN;
         end
         bmhq_pkg::S_DNL: begin
            state_in = bmhq_pkg::S_DNR;
         end
         bmhq_pkg::S_DNR: begin
            if (cur_ff >= cval) begin
               state_in = bmhq_pkg::S_EMIT;
            end else begin
               state_in = (next_left < count_x) ? bmhq_pkg::S_DNL : bmhq_pkg::S_FIN;
            end
         end
         bmhq_pkg::S_FIN: begin
            state_in = bmhq_pkg::S_EMIT;
         end
         bmhq_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = bmhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and RAM control. The moving value stays in cur_ff; every write goes
   // to the current hole while the read in the same cycle is to a different entry
   // (parent or child of the next hole), so no forwarding is needed.
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      child_in     = child_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;

      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            rd_addr = (req_func == bmhq_pkg::FUNC_INSERT) ? par_cnt : '0;
            if (req_fire) begin
               result_in = '0;
               if (req_func == bmhq_pkg::FUNC_INSERT) begin
                  if (is_full) begin
                     status_in = bmhq_pkg::ST_FULL;
                  end else begin
                     status_in = bmhq_pkg::ST_INSERTED;
                     cur_in    = req_value;
                     pos_in    = AW'(count_ff);
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  if (is_empty) begin
                     status_in = bmhq_pkg::ST_EMPTY;
                  end else begin
                     status_in = bmhq_pkg::ST_EXTRACTED;
                     count_in  = count_ff - 1'b1;
                  end
               end
            end
         end
         bmhq_pkg::S_UPCMP: begin
            wr_en = 1'b1;
            if (cur_ff > rd_data) begin
               // parent moves down into the hole
               wr_data = rd_data;
               pos_in  = pos_par;
               rd_addr = pos_par2;
            end
         end
         bmhq_pkg::S_ROOT: begin
            result_in = rd_data;
            rd_addr   = AW'(count_ff);   // last entry
         end
         bmhq_pkg::S_LAST: begin
            cur_in  = rd_data;
            pos_in  = '0;
            rd_addr = AW'(1);
         end
         bmhq_pkg::S_DNL: begin
            child_in = rd_data;
            rd_addr  = AW'(right_ix);
         end
         bmhq_pkg::S_DNR: begin
            wr_en = 1'b1;
            if (cur_ff < cval) begin
               // larger child moves up into the hole
               wr_data = cval;
               pos_in  = cidx;
               rd_addr = AW'(next_left);
            end
         end
         bmhq_pkg::S_FIN: begin
            wr_en = 1'b1;
         end
         bmhq_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSPW'({count_ff, result_ff});
               rsp_user_in  = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      child_ff    <= child_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// ===== rtl/bmhq_checker.sv =====
// Port-level checker for the binary max-heap priority queue, bound to the top level.
// Depends on bmhq_pkg.
module bmhq_checker #(
   parameter int CAPACITY    = bmhq_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF,
   localparam int CW   = $clog2(CAPACITY + 1),
   localparam int RSPW = ((VALUE_WIDTH + CW + 7) / 8) * 8
) (
   input logic            clock,
   input logic            reset,
   input logic            req_tvalid,
   input logic            req_tready,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [RSPW-1:0] rsp_tdata,
   input logic [1:0]      rsp_tuser
);

   logic [VALUE_WIDTH-1:0] rsp_max;
   logic [CW-1:0]          rsp_occ;

   assign rsp_max = rsp_tdata[VALUE_WIDTH-1:0];
   assign rsp_occ = rsp_tdata[VALUE_WIDTH+CW-1:VALUE_WIDTH];

   // empty extract reports nothing held and no value
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bmhq_pkg::ST_EMPTY) |-> (rsp_occ == '0) && (rsp_max == '0))
      else $error("empty status with nonzero occupancy or value");

   // a dropped insert only happens at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bmhq_pkg::ST_FULL) |-> (rsp_occ == CW'(CAPACITY)))
      else $error("full status below capacity");

   // a successful insert leaves at least one entry, and no value is reported
   a_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bmhq_pkg::ST_INSERTED) |-> (rsp_occ != '0) && (rsp_max == '0))
      else $error("insert result malformed");

   // one item in flight: no new item is taken right after an accept
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind binary_max_heap_queue bmhq_checker #(
   .CAPACITY   (CAPACITY),
   .VALUE_WIDTH(VALUE_WIDTH)
) u_bmhq_checker (.*);

// ===== tb/tb_binary_max_heap_queue.sv =====
// Self-checking testbench for binary_max_heap_queue: directed table, random mix,
// fill to capacity and long sift-down paths, checked against an in-bench heap predictor
// or, for typed directed items, the given results. Depends on bmhq_pkg and the block's RTL.
module tb_binary_max_heap_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW   = bmhq_pkg::VALUE_WIDTH_DEF;
   localparam int CAP  = bmhq_pkg::CAPACITY_DEF;
   localparam int CW   = $clog2(CAP + 1);
   localparam int REQW = ((VW + 7) / 8) * 8;
   localparam int RSPW = ((VW + CW + 7) / 8) * 8;
   localparam logic [VW-1:0] VAL_MAX = {VW{1'b1}};

   typedef struct packed {
      logic [VW-1:0] max_value;
      logic [1:0]    status;
      logic [CW-1:0] occupancy;
   } heap_result_type;

   typedef struct packed {
      logic            func;
      logic [VW-1:0]   value;
      logic            typed;    // expected result given below, else predicted
      heap_result_type want;
   } heap_case_type;

   // Directed items: empty extract, extremes, ignored value on extract, ties.
   localparam heap_case_type PLAN [24] = '{
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b1, '{'0,      bmhq_pkg::ST_EMPTY,     11'd0}},
      '{bmhq_pkg::FUNC_EXTRACT, VAL_MAX,      1'b1, '{'0,      bmhq_pkg::ST_EMPTY,     11'd0}},
      '{bmhq_pkg::FUNC_INSERT,  VAL_MAX,      1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd1}},
      '{bmhq_pkg::FUNC_INSERT,  '0,           1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd2}},
      '{bmhq_pkg::FUNC_EXTRACT, VAL_MAX,      1'b1, '{VAL_MAX, bmhq_pkg::ST_EXTRACTED, 11'd1}},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b1, '{'0,      bmhq_pkg::ST_EXTRACTED, 11'd0}},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b1, '{'0,      bmhq_pkg::ST_EMPTY,     11'd0}},
      '{bmhq_pkg::FUNC_INSERT,  30'd5,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd1}},
      '{bmhq_pkg::FUNC_INSERT,  30'd5,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd2}},
      '{bmhq_pkg::FUNC_INSERT,  30'd5,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd3}},
      '{bmhq_pkg::FUNC_INSERT,  30'd9,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd4}},
      '{bmhq_pkg::FUNC_INSERT,  30'd9,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd5}},
      '{bmhq_pkg::FUNC_INSERT,  30'd1,        1'b1, '{'0,      bmhq_pkg::ST_INSERTED,  11'd6}},
      '{bmhq_pkg::FUNC_EXTRACT, 30'h2AAAAAAA, 1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_INSERT,  30'h2AAAAAAA, 1'b0, '0},
      '{bmhq_pkg::FUNC_INSERT,  30'h15555555, 1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, 30'h15555555, 1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b0, '0},
      '{bmhq_pkg::FUNC_EXTRACT, '0,           1'b1, '{'0,      bmhq_pkg::ST_EMPTY,     11'd0}}
   };

   logic            clock      = 1'b0;
   logic            reset      = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [REQW-1:0] req_tdata  = '0;
   logic [0:0]      req_tuser  = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RSPW-1:0] rsp_tdata;
   logic [1:0]      rsp_tuser;

   // predictor state
   logic [VW-1:0] heap_mirror [CAP];
   int unsigned   heap_count = 0;

   heap_result_type heap_expect_q [$];
   int              n_errors    = 0;
   int              n_checked   = 0;
   int              n_status [4] = '{0, 0, 0, 0};
   int              stall_left  = 0;
   bit              no_gaps     = 1'b0;

   binary_max_heap_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("tb_binary_max_heap_queue failed");
      $finish;
   end

   // Applies one operation to the mirror heap and returns the result it yields.
   function automatic heap_result_type heap_apply(logic func, logic [VW-1:0] value);
      heap_result_type r;
      int unsigned     pos;
      int unsigned     up;
      int unsigned     lft;
      int unsigned     pick;
      logic [VW-1:0]   tmp;
      r = '0;
      if (func == bmhq_pkg::FUNC_INSERT) begin
         if (heap_count >= CAP) begin
            r.status = bmhq_pkg::ST_FULL;
         end else begin
            pos = heap_count;
            heap_mirror[pos] = value;
            heap_count++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_mirror[pos] <= heap_mirror[up]) break;
               tmp = heap_mirror[pos];
               heap_mirror[pos] = heap_mirror[up];
               heap_mirror[up] = tmp;
               pos = up;
            end
            r.status = bmhq_pkg::ST_INSERTED;
         end
      end else begin
         if (heap_count == 0) begin
            r.status = bmhq_pkg::ST_EMPTY;
         end else begin
            r.max_value = heap_mirror[0];
            heap_count--;
            heap_mirror[0] = heap_mirror[heap_count];
            pos = 0;
            forever begin
               lft = 2 * pos + 1;
               if (lft >= heap_count) break;
               pick = lft;
               // left child wins a tie
               if (lft + 1 < heap_count && heap_mirror[lft + 1] > heap_mirror[lft])
                  pick = lft + 1;
               if (heap_mirror[pos] >= heap_mirror[pick]) break;
               tmp = heap_mirror[pos];
               heap_mirror[pos] = heap_mirror[pick];
               heap_mirror[pick] = tmp;
               pos = pick;
            end
            r.status = bmhq_pkg::ST_EXTRACTED;
         end
      end
      r.occupancy = heap_count[CW-1:0];
      return r;
   endfunction

   // Mix of extremes, small values that collide often, and full-width values.
   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return VAL_MAX;
         2, 3:    return VW'($urandom_range(0, 7));
         4:       return VAL_MAX - VW'($urandom_range(0, 3));
         default: return VW'($urandom());
      endcase
   endfunction

   task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
      n_errors++;
      $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   task automatic send_op(logic func, logic [VW-1:0] value, logic typed,
                          heap_result_type want);
      int              gap;
      heap_result_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(REQW - VW){1'b0}}, value};
      do @(posedge clock); while (!req_tready);
      // item taken at this edge; valid stays high until the next call or drain_results decides
      predicted = heap_apply(func, value);
      if (typed) predicted = want;
      heap_expect_q = {heap_expect_q, predicted};
      n_status[predicted.status]++;
   endtask

   // Holds the sender until every outstanding result has been seen.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (heap_expect_q.size() != 0);
   endtask

   task automatic check_result();
      heap_result_type got;
      heap_result_type want;
      got.max_value = rsp_tdata[VW-1:0];
      got.occupancy = rsp_tdata[VW +: CW];
      got.status    = rsp_tuser;
      n_checked++;
      if (heap_expect_q.size() == 0) begin
         flag_mismatch("result with nothing outstanding, status", got.status, 0);
         return;
      end
      want = heap_expect_q.pop_front();
      if (got.max_value !== want.max_value)
         flag_mismatch("max_value", got.max_value, want.max_value);
      if (got.status !== want.status)
         flag_mismatch("status", got.status, want.status);
      if (got.occupancy !== want.occupancy)
         flag_mismatch("occupancy", got.occupancy, want.occupancy);
   endtask

   // Result side: take an item, then draw a stall before the next one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            stall_left = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall_left != 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (stall_left > 1) stall_left--;
            else rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         send_op(PLAN[i].func, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
      end
      drain_results();

      // random mix on a small heap, second half back to back
      for (k = 0; k < 50; k++) begin
         no_gaps = (k >= 25);
         send_op(($urandom_range(0, 99) < 60) ? bmhq_pkg::FUNC_INSERT : bmhq_pkg::FUNC_EXTRACT,
                 pick_value(), 1'b0, '0);
      end
      drain_results();

      // fill to capacity
      while (heap_count < CAP) begin
         no_gaps = (heap_count >= 400 && heap_count < 520);
         send_op(bmhq_pkg::FUNC_INSERT, pick_value(), 1'b0, '0);
      end
      no_gaps = 1'b0;
      for (k = 0; k < 4; k++) send_op(bmhq_pkg::FUNC_INSERT, pick_value(), 1'b0, '0);
      // bounce on the full boundary
      for (k = 0; k < 4; k++) begin
         send_op(bmhq_pkg::FUNC_EXTRACT, pick_value(), 1'b0, '0);
         send_op(bmhq_pkg::FUNC_INSERT, pick_value(), 1'b0, '0);
         send_op(bmhq_pkg::FUNC_INSERT, pick_value(), 1'b0, '0);
      end
      drain_results();

      // extracts from a nearly full heap take the longest sift-down paths
      for (k = 0; k < 40; k++) begin
         no_gaps = (k >= 20);
         send_op(($urandom_range(0, 9) == 0) ? bmhq_pkg::FUNC_INSERT : bmhq_pkg::FUNC_EXTRACT,
                 pick_value(), 1'b0, '0);
      end
      no_gaps = 1'b0;

      drain_results();
      repeat (40) @(posedge clock);
      $display("checked %0d results: %0d inserts, %0d extracts, %0d empty extracts,",
               n_checked, n_status[bmhq_pkg::ST_INSERTED], n_status[bmhq_pkg::ST_EXTRACTED],
               n_status[bmhq_pkg::ST_EMPTY]);
      $display("%0d inserts dropped at full capacity, %0d mismatches",
               n_status[bmhq_pkg::ST_FULL], n_errors);
      if (n_errors == 0)
         $display("tb_binary_max_heap_queue passed");
      else
         $display("tb_binary_max_heap_queue failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_max_heap_queue.sv
rtl/bmhq_checker.sv
tb/tb_binary_max_heap_queue.sv
